// ===== hw/rtl/tac_pkg.sv =====
// Package for the token admission control block: status and opcode codes,
// register indexes, sequencer states and the structs between top and id table.
// No dependencies.
package tac_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned IdBitsDefault     = 32;

  localparam int unsigned FrameIdW   = 32;
  localparam int unsigned TokenW     = 5;
  localparam int unsigned IdxMaxW    = 8;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [TokenW-1:0] TokenLimitReset = 5'd16;

  localparam logic OpAdmit  = 1'b0;
  localparam logic OpReturn = 1'b1;

  localparam logic RegTokenLimit = 1'b0;
  localparam logic RegBlockMode  = 1'b1;

  typedef enum logic [2:0] {
    StatusAdmitted  = 3'd0,
    StatusDropped   = 3'd1,
    StatusHeld      = 3'd2,
    StatusAlready   = 3'd3,
    StatusReturned  = 3'd4,
    StatusNotIssued = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StFinish
  } state_e;

  typedef struct packed {
    logic               en;
    logic               set;
    logic [IdxMaxW-1:0] idx;
  } upd_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [IdxMaxW-1:0] hit_idx;
    logic               free;
    logic [IdxMaxW-1:0] free_idx;
  } search_t;

endpackage

// ===== hw/rtl/tac_if.sv =====
// Stream interfaces for admit/return requests and their results.
// Depends on tac_pkg for field widths.
interface tac_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [tac_pkg::FrameIdW-1:0]  pkt_id;
  logic                          already_controlled;

  modport source (output valid, opcode, pkt_id, already_controlled, input ready);
  modport sink   (input valid, opcode, pkt_id, already_controlled, output ready);
endinterface

interface tac_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [tac_pkg::TokenW-1:0]    tokens_free;
  logic [tac_pkg::FrameIdW-1:0]  echo_id;

  modport source (output valid, status, tokens_free, echo_id, input ready);
  modport sink   (input valid, status, tokens_free, echo_id, output ready);
endinterface

// ===== hw/rtl/tac_id_table.sv =====
// Table of issued frame ids with valid bits and a serial search unit.
// One entry is read and compared per cycle. Depends on tac_pkg.
module tac_id_table #(
  parameter int unsigned MAX_ENTRIES = tac_pkg::MaxEntriesDefault,
  parameter int unsigned ID_BITS     = tac_pkg::IdBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ID_BITS-1:0] key_i,
  input  tac_pkg::upd_t      upd_i,
  output tac_pkg::search_t   res_o
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);

  logic [ID_BITS-1:0]     mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [ID_BITS-1:0]     key_q, key_d;
  logic [ID_BITS-1:0]     rd_q;
  logic                   scan_q, scan_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic                   cmp_last_q, cmp_last_d;
  logic [IdxW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic                   free_q, free_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic                   done_q, done_d;
  logic [IdxW-1:0]        upd_idx;

  assign upd_idx = upd_i.idx[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.set) begin
      mem[upd_idx] <= key_q;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i.en) begin
      valid_q[upd_idx] <= upd_i.set;
    end
  end

  always_comb begin
    key_d      = key_q;
    scan_d     = scan_q;
    idx_d      = idx_q;
    cmp_vld_d  = scan_q;
    cmp_idx_d  = idx_q;
    cmp_last_d = scan_q && (idx_q == LastIdx);
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    done_d     = cmp_vld_q && cmp_last_q;

    if (scan_q) begin
      idx_d = idx_q + IdxW'(1);
      if (idx_q == LastIdx) begin
        scan_d = 1'b0;
      end
    end

    if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q] && (rd_q == key_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (!valid_q[cmp_idx_q] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end

    if (start_i) begin
      key_d  = key_i;
      scan_d = 1'b1;
      idx_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= 1'b0;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      scan_q     <= scan_d;
      idx_q      <= idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_last_q <= cmp_last_d;
      cmp_idx_q  <= cmp_idx_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign res_o.done     = done_q;
  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = tac_pkg::IdxMaxW'(hit_idx_q);
  assign res_o.free     = free_q;
  assign res_o.free_idx = tac_pkg::IdxMaxW'(free_idx_q);

endmodule

// ===== hw/rtl/token_admission_control_top.sv =====
// Token admission control gate: request/result streams, APB register port.
// Depends on tac_pkg, tac_if and tac_id_table.
//
// One request is taken at a time. An admit that carries a flow control mark,
// or finds no token free, goes straight to the finish state. Any other
// admit and every return searches the issued-id table, one entry per cycle
// through its single read port, and answers from the finish state once the
// search is done. A new request is taken as soon as the previous one has
// left the sequencer, even while its result still waits in the output
// register. Writing token_limit reloads the free token count to
// min(token_limit, MAX_ENTRIES); issued entries stay.
module token_admission_control_top #(
  parameter int unsigned MAX_ENTRIES = tac_pkg::MaxEntriesDefault,
  parameter int unsigned ID_BITS     = tac_pkg::IdBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tac_req_if.sink                        req_i,
  tac_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tac_pkg::CfgAddrW-1:0]   paddr,
  input  logic [tac_pkg::CfgDataW-1:0]   pwdata,
  output logic [tac_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned TokenW = tac_pkg::TokenW;
  localparam logic [5:0]  MaxClip = (MAX_ENTRIES > 31) ? 6'd31 : 6'(MAX_ENTRIES);

  function automatic logic [TokenW-1:0] clip_limit(logic [TokenW-1:0] v);
    return ({1'b0, v} > MaxClip) ? MaxClip[TokenW-1:0] : v;
  endfunction

  tac_pkg::state_e         state_q, state_d;
  logic [TokenW-1:0]       limit_q, limit_d;
  logic                    block_q, block_d;
  logic [TokenW-1:0]       count_q, count_d;
  logic                    op_q, op_d;
  logic                    marked_q, marked_d;
  logic [tac_pkg::FrameIdW-1:0] id_q, id_d;
  logic                    rsp_vld_q, rsp_vld_d;
  tac_pkg::status_e        rsp_status_q, rsp_status_d;
  logic [TokenW-1:0]       rsp_tokens_q, rsp_tokens_d;
  logic [tac_pkg::FrameIdW-1:0] rsp_id_q, rsp_id_d;
  logic                    cfg_we;
  logic                    start;
  logic [ID_BITS-1:0]      key;
  logic [TokenW-1:0]       eff_limit;
  tac_pkg::upd_t           upd;
  tac_pkg::search_t        res;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign key      = ID_BITS'(req_i.pkt_id);
  assign eff_limit = clip_limit(limit_q);

  always_comb begin
    unique case (paddr[2])
      tac_pkg::RegTokenLimit: prdata = tac_pkg::CfgDataW'(limit_q);
      tac_pkg::RegBlockMode:  prdata = tac_pkg::CfgDataW'(block_q);
      default:                prdata = '0;
    endcase
  end

  tac_id_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
  ) u_id_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .key_i   (key),
    .upd_i   (upd),
    .res_o   (res)
  );

  always_comb begin
    state_d      = state_q;
    limit_d      = limit_q;
    block_d      = block_q;
    count_d      = count_q;
    op_d         = op_q;
    marked_d     = marked_q;
    id_d         = id_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_tokens_d = rsp_tokens_q;
    rsp_id_d     = rsp_id_q;
    req_i.ready  = 1'b0;
    start        = 1'b0;
    upd          = '0;

    if (cfg_we) begin
      unique case (paddr[2])
        tac_pkg::RegTokenLimit: begin
          limit_d = pwdata[TokenW-1:0];
          count_d = clip_limit(pwdata[TokenW-1:0]);
        end
        tac_pkg::RegBlockMode: begin
          block_d = pwdata[0];
        end
        default: ;
      endcase
    end

    unique case (state_q)
      tac_pkg::StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d     = req_i.opcode;
          marked_d = req_i.already_controlled;
          id_d     = req_i.pkt_id;
          if ((req_i.opcode == tac_pkg::OpReturn) ||
              (!req_i.already_controlled && (count_q != '0))) begin
            start   = 1'b1;
            state_d = tac_pkg::StSearch;
          end else begin
            state_d = tac_pkg::StFinish;
          end
        end
      end
      tac_pkg::StSearch: begin
        if (res.done) begin
          state_d = tac_pkg::StFinish;
        end
      end
      tac_pkg::StFinish: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          state_d   = tac_pkg::StIdle;
          rsp_vld_d = 1'b1;
          rsp_id_d  = id_q;
          if (op_q == tac_pkg::OpAdmit) begin
            priority if (marked_q) begin
              rsp_status_d = tac_pkg::StatusAlready;
            end else if (count_q == '0) begin
              rsp_status_d = block_q ? tac_pkg::StatusHeld : tac_pkg::StatusDropped;
            end else if (res.hit) begin
              rsp_status_d = tac_pkg::StatusAdmitted;
              count_d      = count_q - TokenW'(1);
            end else if (res.free) begin
              rsp_status_d = tac_pkg::StatusAdmitted;
              count_d      = count_q - TokenW'(1);
              upd.en       = 1'b1;
              upd.set      = 1'b1;
              upd.idx      = res.free_idx;
            end else begin
              rsp_status_d = tac_pkg::StatusDropped;
            end
          end else begin
            if (res.hit) begin
              rsp_status_d = tac_pkg::StatusReturned;
              upd.en       = 1'b1;
              upd.set      = 1'b0;
              upd.idx      = res.hit_idx;
              if (count_q < eff_limit) begin
                count_d = count_q + TokenW'(1);
              end
            end else begin
              rsp_status_d = tac_pkg::StatusNotIssued;
            end
          end
          rsp_tokens_d = count_d;
        end
      end
      default: begin
        state_d = tac_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tac_pkg::StIdle;
      limit_q   <= tac_pkg::TokenLimitReset;
      block_q   <= 1'b0;
      count_q   <= clip_limit(tac_pkg::TokenLimitReset);
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      limit_q   <= limit_d;
      block_q   <= block_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    marked_q     <= marked_d;
    id_q         <= id_d;
    rsp_status_q <= rsp_status_d;
    rsp_tokens_q <= rsp_tokens_d;
    rsp_id_q     <= rsp_id_d;
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.tokens_free = rsp_tokens_q;
  assign rsp_o.echo_id     = rsp_id_q;

endmodule

// ===== hw/rtl/tac_checker.sv =====
// Port-level checks for the token admission control top, attached by bind.
// Depends on tac_pkg for codes and defaults.
module tac_checker #(
  parameter int unsigned MAX_ENTRIES = tac_pkg::MaxEntriesDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [2:0]                    rsp_status,
  input logic [tac_pkg::TokenW-1:0]    rsp_tokens_free,
  input logic [tac_pkg::FrameIdW-1:0]  rsp_echo_id
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one still in progress");

  a_tokens_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_tokens_free <= MAX_ENTRIES))
    else $error("free token count above table size");

  a_admit_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && (rsp_status == tac_pkg::StatusAdmitted)) |->
      (rsp_tokens_free < MAX_ENTRIES))
    else $error("admitted result shows a full token pool");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_tokens_free) &&
       $stable(rsp_echo_id)))
    else $error("stalled result changed");

endmodule

bind token_admission_control_top tac_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_tac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_status      (rsp_o.status),
  .rsp_tokens_free (rsp_o.tokens_free),
  .rsp_echo_id     (rsp_o.echo_id)
);

// ===== dv/tb_token_admission_control_top.sv =====
// Testbench for token_admission_control_top: directed and random admit/return
// traffic under bursty sending and receiver stalls, checked against an in-bench
// model of the token count and issued-id table. Depends on tac_pkg, tac_if and the top.
module tb_token_admission_control_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tac_pkg::*;

  localparam int unsigned TableDepth = MaxEntriesDefault;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PoolSize   = 20;

  typedef struct {
    logic                op;
    logic [FrameIdW-1:0] id;
    logic                mark;
  } frame_req_t;

  typedef struct {
    status_e             status;
    logic [TokenW-1:0]   tokens;
    logic [FrameIdW-1:0] id;
  } gate_rsp_t;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadySparse
  } ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  tac_req_if req_if ();
  tac_rsp_if rsp_if ();

  token_admission_control_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [FrameIdW-1:0] issued_id  [TableDepth];
  logic                issued_vld [TableDepth];
  logic [TokenW-1:0]   free_tokens;
  logic [TokenW-1:0]   limit_reg;
  logic                hold_mode;

  frame_req_t  pending_q  [$];
  gate_rsp_t   expected_q [$];
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  logic        req_xfer     = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  ready_mode_e ready_mode   = ReadyAlways;

  always #10 clk_i = ~clk_i;

  function automatic logic [TokenW-1:0] token_ceiling();
    return (limit_reg > TokenW'(TableDepth)) ? TokenW'(TableDepth) : limit_reg;
  endfunction

  function automatic gate_rsp_t admit_or_return(frame_req_t r);
    gate_rsp_t res;
    int        hit;
    int        slot;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < TableDepth; i++) begin
      if (hit < 0 && issued_vld[i] && issued_id[i] == r.id) hit = i;
      if (slot < 0 && !issued_vld[i]) slot = i;
    end
    res.id = r.id;
    if (r.op == OpAdmit) begin
      if (r.mark) begin
        res.status = StatusAlready;
      end else if (free_tokens == '0) begin
        res.status = hold_mode ? StatusHeld : StatusDropped;
      end else if (hit >= 0) begin
        free_tokens--;
        res.status = StatusAdmitted;
      end else if (slot >= 0) begin
        issued_id[slot]  = r.id;
        issued_vld[slot] = 1'b1;
        free_tokens--;
        res.status = StatusAdmitted;
      end else begin
        res.status = StatusDropped;
      end
    end else if (hit < 0) begin
      res.status = StatusNotIssued;
    end else begin
      issued_vld[hit] = 1'b0;
      if (free_tokens < token_ceiling()) free_tokens++;
      res.status = StatusReturned;
    end
    res.tokens = free_tokens;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [FrameIdW-1:0] got,
                                 logic [FrameIdW-1:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic queue_item(logic op, logic [FrameIdW-1:0] id, logic mark);
    pending_q.push_back(frame_req_t'{op, id, mark});
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(idx) << 2;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegTokenLimit) begin
      limit_reg   = value[TokenW-1:0];
      free_tokens = token_ceiling();
    end else begin
      hold_mode = value[0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    gate_rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, echo_id", rsp_if.echo_id, '0);
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.status != want.status)
          report_mismatch("status", FrameIdW'(rsp_if.status), FrameIdW'(want.status));
        if (rsp_if.tokens_free != want.tokens)
          report_mismatch("tokens_free", FrameIdW'(rsp_if.tokens_free),
                          FrameIdW'(want.tokens));
        if (rsp_if.echo_id != want.id)
          report_mismatch("echo_id", rsp_if.echo_id, want.id);
      end
    end
    if (req_if.valid && req_if.ready)
      expected_q.push_back(admit_or_return(frame_req_t'{req_if.opcode, req_if.pkt_id,
                                                        req_if.already_controlled}));
    req_xfer <= req_if.valid && req_if.ready;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    frame_req_t nxt;
    if (!req_if.valid || req_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        req_if.valid              <= 1'b1;
        req_if.opcode             <= nxt.op;
        req_if.pkt_id             <= nxt.id;
        req_if.already_controlled <= nxt.mark;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (ready_mode)
      ReadyAlways: begin
        rsp_if.ready <= 1'b1;
      end
      ReadyCoin: begin
        rsp_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        rsp_if.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  initial begin
    logic [FrameIdW-1:0] pool [PoolSize];
    int unsigned         limit_plan [8];
    logic                hold_plan  [8];
    int unsigned         pick;
    limit_plan                = '{16, 3, 0, 1, 16, 9, 0, 16};
    hold_plan                 = '{0, 1, 1, 0, 1, 0, 0, 1};
    rst_ni                    = 1'b0;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    req_if.valid              = 1'b0;
    req_if.opcode             = OpAdmit;
    req_if.pkt_id             = '0;
    req_if.already_controlled = 1'b0;
    rsp_if.ready              = 1'b1;
    limit_reg                 = TokenLimitReset;
    hold_mode                 = 1'b0;
    free_tokens               = token_ceiling();
    for (int i = 0; i < TableDepth; i++) begin
      issued_id[i]  = '0;
      issued_vld[i] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // unknown return, admit, duplicate admit, marked admit, return with mark set
    queue_item(OpReturn, '0, 1'b0);
    queue_item(OpAdmit, '0, 1'b0);
    queue_item(OpAdmit, '0, 1'b0);
    queue_item(OpAdmit, '1, 1'b1);
    queue_item(OpReturn, '0, 1'b1);
    settle();

    cfg_write(RegTokenLimit, 0);
    cfg_write(RegBlockMode, 1);
    queue_item(OpAdmit, '0, 1'b0);
    queue_item(OpReturn, '0, 1'b0);
    settle();

    cfg_write(RegBlockMode, 0);
    queue_item(OpAdmit, '1, 1'b0);
    settle();

    // fill the table, reload the count, then hit a full table and an excess transfer back
    cfg_write(RegTokenLimit, 16);
    for (int i = 0; i < TableDepth; i++)
      queue_item(OpAdmit, (i == 0) ? '1 : FrameIdW'($urandom), 1'b0);
    settle();
    cfg_write(RegTokenLimit, 16);
    queue_item(OpAdmit, FrameIdW'($urandom), 1'b0);
    queue_item(OpReturn, '1, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p % 2 == 0) begin
        for (int i = 0; i < TableDepth; i++)
          if (issued_vld[i]) queue_item(OpReturn, issued_id[i], 1'($urandom_range(0, 1)));
        settle();
      end
      cfg_write(RegTokenLimit, limit_plan[p]);
      cfg_write(RegBlockMode, CfgDataW'(hold_plan[p]));
      for (int k = 0; k < PoolSize; k++)
        pool[k] = FrameIdW'($urandom);
      pool[0] = '0;
      pool[1] = '1;
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 48)
          queue_item(OpAdmit, pool[$urandom_range(0, PoolSize - 1)], 1'b0);
        else if (pick < 88)
          queue_item(OpReturn, pool[$urandom_range(0, PoolSize - 1)],
                     1'($urandom_range(0, 1)));
        else if (pick < 93)
          queue_item(OpAdmit, pool[$urandom_range(0, PoolSize - 1)], 1'b1);
        else if (pick < 97)
          queue_item(OpReturn, FrameIdW'($urandom), 1'($urandom_range(0, 1)));
        else
          queue_item(OpAdmit, FrameIdW'($urandom), 1'b0);
      end
      settle();
    end

    repeat (30) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results never transferred", FrameIdW'(expected_q.size()), '0);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
